// ===== rtl/core/crml_pkg.sv =====
// ----------------------------------------------------------------------------
// crml_pkg
// Shared types and constants for the circle region mask lookup: table entry
// layout, pipeline tag, command and register codes, controller states.
// ----------------------------------------------------------------------------
package crml_pkg;

	localparam int COORD_W  = 16;
	localparam int MASK_W   = 16;
	localparam int RADIUS_W = 15;
	localparam int COUNT_W  = 7;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int D2_W     = SQ_W + 1;
	localparam int R2_W     = 2 * RADIUS_W;
	localparam int CFG_W    = 15;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd448;
	localparam logic [COUNT_W-1:0]  COUNT_RESET  = 7'd0;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [MASK_W-1:0]         mnum;
	} entry_t;

	typedef struct packed {
		logic vld;
		logic last;
	} tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/circle_region_mask_lookup_top.sv =====
// ----------------------------------------------------------------------------
// circle_region_mask_lookup_top
// Circular mask region lookup: load words fill the mask table, query words
// return the mask number of the last table entry whose circle holds the point.
// ----------------------------------------------------------------------------
// A load word writes one table slot and returns nothing. A query word scans
// N table entries, N being entry_count limited to MAX_ENTRIES: the single
// read port of the table memory gives one entry per cycle, and the read,
// square and compare stages follow. When N is zero the scan is skipped. The
// block takes one word at a time; a finished result sits in the output
// register while the next word is accepted, and a query that finishes while
// that register still holds a stalled result waits for it. The user must
// write radius and entry count on the config port only while the block is
// idle; the block itself does not enforce this.
module circle_region_mask_lookup_top #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  command,
	input  logic [5:0]                            entry_index,
	input  logic signed [crml_pkg::COORD_W-1:0]   center_x,
	input  logic signed [crml_pkg::COORD_W-1:0]   center_y,
	input  logic [crml_pkg::MASK_W-1:0]           entry_mask,
	input  logic signed [crml_pkg::COORD_W-1:0]   point_x,
	input  logic signed [crml_pkg::COORD_W-1:0]   point_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [crml_pkg::MASK_W-1:0]           mask_number,
	output logic                                  hit,
	input  logic                                  cfg_wr_en,
	input  logic                                  cfg_index,
	input  logic [crml_pkg::CFG_W-1:0]            cfg_data
);

	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W  = (ADDR_W > 6) ? ADDR_W : 6;

	crml_pkg::state_t                    state_q;
	crml_pkg::state_t                    state_d;
	logic [crml_pkg::RADIUS_W-1:0]       radius_q;
	logic [crml_pkg::COUNT_W-1:0]        count_q;
	logic [ADDR_W-1:0]                   addr_q;
	logic [ADDR_W-1:0]                   last_q;
	logic signed [crml_pkg::COORD_W-1:0] px_q;
	logic signed [crml_pkg::COORD_W-1:0] py_q;
	logic [crml_pkg::R2_W-1:0]           r2_q;
	logic                                out_valid_q;
	logic [crml_pkg::MASK_W-1:0]         mask_q;
	logic                                hit_q;

	logic [CNT_W-1:0]                    n_c;
	logic [IDX_W-1:0]                    idx_ext;
	logic                                load_ok;
	logic                                start;
	logic                                wr_en;
	logic                                rd_en;
	logic                                out_load;
	crml_pkg::entry_t                    wr_data;
	crml_pkg::tag_t                      rd_tag;
	crml_pkg::entry_t                    ent_s1;
	crml_pkg::tag_t                      tag_s1;
	logic [crml_pkg::MASK_W-1:0]         found;
	logic                                found_hit;
	logic                                done;

	always_comb begin
		if (32'(count_q) > MAX_ENTRIES) begin
			n_c = CNT_W'(MAX_ENTRIES);
		end else begin
			n_c = CNT_W'(count_q);
		end
	end

	assign idx_ext      = IDX_W'(entry_index);
	assign load_ok      = (32'(entry_index) < MAX_ENTRIES);
	assign wr_data.cx   = center_x;
	assign wr_data.cy   = center_y;
	assign wr_data.mnum = entry_mask;
	assign rd_tag.vld   = rd_en;
	assign rd_tag.last  = (addr_q == last_q);

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		start    = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			crml_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (command == crml_pkg::CMD_QUERY) begin
						start   = 1'b1;
						state_d = (n_c == '0) ? crml_pkg::ST_DONE : crml_pkg::ST_SCAN;
					end else begin
						wr_en = load_ok;
					end
				end
			end
			crml_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (addr_q == last_q) begin
					state_d = crml_pkg::ST_DRAIN;
				end
			end
			crml_pkg::ST_DRAIN: begin
				if (done) begin
					state_d = crml_pkg::ST_DONE;
				end
			end
			crml_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = crml_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crml_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crml_pkg::ST_IDLE;
			radius_q    <= crml_pkg::RADIUS_RESET;
			count_q     <= crml_pkg::COUNT_RESET;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					crml_pkg::REG_RADIUS: radius_q <= cfg_data[crml_pkg::RADIUS_W-1:0];
					crml_pkg::REG_COUNT:  count_q  <= cfg_data[crml_pkg::COUNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (start) begin
				addr_q <= '0;
			end else if (rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			px_q   <= point_x;
			py_q   <= point_y;
			r2_q   <= crml_pkg::R2_W'(radius_q) * crml_pkg::R2_W'(radius_q);
			last_q <= ADDR_W'(n_c - 1'b1);
		end
		if (out_load) begin
			mask_q <= found;
			hit_q  <= found_hit;
		end
	end

	crml_table #(
		.DEPTH  (MAX_ENTRIES),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (idx_ext[ADDR_W-1:0]),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (addr_q),
		.rd_tag     (rd_tag),
		.rd_data_s1 (ent_s1),
		.rd_tag_s1  (tag_s1)
	);

	crml_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (start),
		.px        (px_q),
		.py        (py_q),
		.r2        (r2_q),
		.ent_s1    (ent_s1),
		.tag_s1    (tag_s1),
		.found     (found),
		.found_hit (found_hit),
		.done      (done)
	);

	assign out_valid   = out_valid_q;
	assign mask_number = mask_q;
	assign hit         = hit_q;

endmodule

// ===== rtl/core/crml_table.sv =====
// ----------------------------------------------------------------------------
// crml_table
// Mask table memory: one write port, one read port with registered data.
// The read tag travels alongside the read data.
// ----------------------------------------------------------------------------
module crml_table #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  crml_pkg::entry_t   wr_data,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	input  crml_pkg::tag_t     rd_tag,
	output crml_pkg::entry_t   rd_data_s1,
	output crml_pkg::tag_t     rd_tag_s1
);

	crml_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_tag_s1 <= '0;
		end else begin
			rd_tag_s1 <= rd_tag;
		end
	end

endmodule

// ===== rtl/core/crml_dist.sv =====
// ----------------------------------------------------------------------------
// crml_dist
// Containment test pipeline: squared distance per entry, compare against
// radius squared, keep the last containing mask number.
// ----------------------------------------------------------------------------
module crml_dist (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   clear,
	input  logic signed [crml_pkg::COORD_W-1:0]    px,
	input  logic signed [crml_pkg::COORD_W-1:0]    py,
	input  logic [crml_pkg::R2_W-1:0]              r2,
	input  crml_pkg::entry_t                       ent_s1,
	input  crml_pkg::tag_t                         tag_s1,
	output logic [crml_pkg::MASK_W-1:0]            found,
	output logic                                   found_hit,
	output logic                                   done
);

	logic signed [crml_pkg::COORD_W:0] dx;
	logic signed [crml_pkg::COORD_W:0] dy;
	logic signed [crml_pkg::COORD_W:0] ax;
	logic signed [crml_pkg::COORD_W:0] ay;
	logic [crml_pkg::MAG_W-1:0]        mx;
	logic [crml_pkg::MAG_W-1:0]        my;
	logic [crml_pkg::SQ_W-1:0]         sqx_s2;
	logic [crml_pkg::SQ_W-1:0]         sqy_s2;
	logic [crml_pkg::MASK_W-1:0]       mnum_s2;
	crml_pkg::tag_t                    tag_s2;
	logic [crml_pkg::D2_W-1:0]         d2;
	logic                              inside_c;
	logic [crml_pkg::MASK_W-1:0]       found_q;
	logic                              hit_q;
	logic                              done_q;

	always_comb begin
		dx = (crml_pkg::COORD_W+1)'(px) - (crml_pkg::COORD_W+1)'(ent_s1.cx);
		dy = (crml_pkg::COORD_W+1)'(py) - (crml_pkg::COORD_W+1)'(ent_s1.cy);
		ax = dx[crml_pkg::COORD_W] ? -dx : dx;
		ay = dy[crml_pkg::COORD_W] ? -dy : dy;
		mx = ax[crml_pkg::MAG_W-1:0];
		my = ay[crml_pkg::MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		sqx_s2  <= crml_pkg::SQ_W'(mx) * crml_pkg::SQ_W'(mx);
		sqy_s2  <= crml_pkg::SQ_W'(my) * crml_pkg::SQ_W'(my);
		mnum_s2 <= ent_s1.mnum;
	end

	assign d2       = crml_pkg::D2_W'(sqx_s2) + crml_pkg::D2_W'(sqy_s2);
	assign inside_c = (d2 <= crml_pkg::D2_W'(r2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2  <= '0;
			found_q <= '0;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			tag_s2 <= tag_s1;
			if (clear) begin
				found_q <= '0;
				hit_q   <= 1'b0;
				done_q  <= 1'b0;
			end else begin
				if (tag_s2.vld && inside_c) begin
					found_q <= mnum_s2;
					hit_q   <= 1'b1;
				end
				done_q <= tag_s2.vld && tag_s2.last;
			end
		end
	end

	assign found     = found_q;
	assign found_hit = hit_q;
	assign done      = done_q;

endmodule

// ===== sim/circle_region_mask_lookup_top_tb.sv =====
// ----------------------------------------------------------------------------
// circle_region_mask_lookup_top_tb
// Self-checking bench for the circle region mask lookup. Load words fill a
// shadow copy of the mask table, and each query word is looked up in that copy
// to get the expected mask number and hit flag. A scoreboard class compares
// these with the results that leave the block, in order. Radius and entry
// count change between phases, while the block is idle. Both handshake sides
// idle at random, and one phase holds the output off for a long stretch.
// ----------------------------------------------------------------------------
module circle_region_mask_lookup_top_tb;

	localparam int MAX_ENTRIES    = 64;
	localparam int SETTLE_CYCLES  = MAX_ENTRIES + 16;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_WORDS    = 165;

	typedef struct {
		logic [crml_pkg::MASK_W-1:0] mnum;
		logic                        found;
	} lookup_t;

	class mask_scoreboard;
		crml_pkg::entry_t              region_table [MAX_ENTRIES];
		logic [crml_pkg::RADIUS_W-1:0] radius;
		logic [crml_pkg::COUNT_W-1:0]  entry_count;
		lookup_t                       pending_lookups [$];
		int                            errors;

		function new();
			radius      = crml_pkg::RADIUS_RESET;
			entry_count = crml_pkg::COUNT_RESET;
			errors      = 0;
		endfunction

		function void set_reg(logic idx, logic [crml_pkg::CFG_W-1:0] data);
			if (idx == crml_pkg::REG_RADIUS)
				radius = data[crml_pkg::RADIUS_W-1:0];
			else
				entry_count = data[crml_pkg::COUNT_W-1:0];
		endfunction

		function void note_word(logic cmd, logic [5:0] idx,
				logic signed [crml_pkg::COORD_W-1:0] cx,
				logic signed [crml_pkg::COORD_W-1:0] cy,
				logic [crml_pkg::MASK_W-1:0] m,
				logic signed [crml_pkg::COORD_W-1:0] px,
				logic signed [crml_pkg::COORD_W-1:0] py);
			lookup_t                             res;
			logic signed [crml_pkg::COORD_W-1:0] ecx, ecy;
			longint                              dx, dy, d2, r2;
			int                                  n;
			if (cmd == crml_pkg::CMD_LOAD) begin
				region_table[idx].cx   = cx;
				region_table[idx].cy   = cy;
				region_table[idx].mnum = m;
				return;
			end
			n = (entry_count > MAX_ENTRIES) ? MAX_ENTRIES : entry_count;
			r2 = longint'(radius) * longint'(radius);
			res.mnum = '0;
			res.found = 1'b0;
			for (int i = 0; i < n; i++) begin
				ecx = region_table[i].cx;
				ecy = region_table[i].cy;
				dx = longint'(px) - longint'(ecx);
				dy = longint'(py) - longint'(ecy);
				d2 = dx * dx + dy * dy;
				if (d2 <= r2) begin
					res.mnum = region_table[i].mnum;
					res.found = 1'b1;
				end
			end
			pending_lookups = {pending_lookups, res};
		endfunction

		function void check_result(logic [crml_pkg::MASK_W-1:0] m, logic h);
			lookup_t want;
			if (pending_lookups.size() == 0) begin
				$error("unexpected result: mask_number %0d hit %0d", m, h);
				errors++;
				return;
			end
			want = pending_lookups.pop_front();
			if (m !== want.mnum) begin
				$error("mask_number: expected %0d, actual %0d", want.mnum, m);
				errors++;
			end
			if (h !== want.found) begin
				$error("hit: expected %0d, actual %0d", want.found, h);
				errors++;
			end
		endfunction

		function int pending();
			return pending_lookups.size();
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_stall;
	logic                                 command;
	logic [5:0]                           entry_index;
	logic signed [crml_pkg::COORD_W-1:0]  center_x;
	logic signed [crml_pkg::COORD_W-1:0]  center_y;
	logic [crml_pkg::MASK_W-1:0]          entry_mask;
	logic signed [crml_pkg::COORD_W-1:0]  point_x;
	logic signed [crml_pkg::COORD_W-1:0]  point_y;
	logic                                 out_valid;
	logic                                 out_stall;
	logic [crml_pkg::MASK_W-1:0]          mask_number;
	logic                                 hit;
	logic                                 cfg_wr_en;
	logic                                 cfg_index;
	logic [crml_pkg::CFG_W-1:0]           cfg_data;

	mask_scoreboard sb;
	bit             hold_req;
	bit             no_idle;
	int             idle_cycles;

	circle_region_mask_lookup_top #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.entry_index(entry_index),
		.center_x   (center_x),
		.center_y   (center_y),
		.entry_mask (entry_mask),
		.point_x    (point_x),
		.point_y    (point_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mask_number(mask_number),
		.hit        (hit),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(mask_number, hit);
		if (arst_n && in_valid && !in_stall)
			sb.note_word(command, entry_index, center_x, center_y, entry_mask,
				point_x, point_y);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("circle_region_mask_lookup_top test failed");
				$finish;
			end
		end
	end

	initial begin : receiver
		int run;
		bit st;
		out_stall = 1'b0;
		run = 0;
		st = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				st = 1'b1;
				run = LONG_HOLD;
			end else if (run <= 0) begin
				if (st || no_idle) begin
					st = 1'b0;
					run = no_idle ? 16 : $urandom_range(1, 24);
				end else begin
					run = pick_gap();
					st = (run != 0);
					if (run == 0)
						run = $urandom_range(1, 8);
				end
			end
			out_stall <= st;
			run--;
		end
	end

	task automatic send_word(input logic cmd, input logic [5:0] idx,
			input logic signed [crml_pkg::COORD_W-1:0] cx,
			input logic signed [crml_pkg::COORD_W-1:0] cy,
			input logic [crml_pkg::MASK_W-1:0] m,
			input logic signed [crml_pkg::COORD_W-1:0] px,
			input logic signed [crml_pkg::COORD_W-1:0] py);
		int gap;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command     <= cmd;
		entry_index <= idx;
		center_x    <= cx;
		center_y    <= cy;
		entry_mask  <= m;
		point_x     <= px;
		point_y     <= py;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_load(input logic [5:0] idx,
			input logic signed [crml_pkg::COORD_W-1:0] cx,
			input logic signed [crml_pkg::COORD_W-1:0] cy,
			input logic [crml_pkg::MASK_W-1:0] m);
		send_word(crml_pkg::CMD_LOAD, idx, cx, cy, m, 16'($urandom), 16'($urandom));
	endtask

	task automatic send_query(input logic signed [crml_pkg::COORD_W-1:0] px,
			input logic signed [crml_pkg::COORD_W-1:0] py);
		send_word(crml_pkg::CMD_QUERY, 6'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), px, py);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [crml_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [crml_pkg::COORD_W-1:0] random_coord();
		if ($urandom_range(0, 1))
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 2047)) - 1024);
	endfunction

	function automatic logic [crml_pkg::MASK_W-1:0] random_mask();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return 16'($urandom);
	endfunction

	task automatic random_query();
		int                                  n, j, w, sel;
		logic signed [crml_pkg::COORD_W-1:0] qx, qy, ecx, ecy;
		n = (sb.entry_count > MAX_ENTRIES) ? MAX_ENTRIES : sb.entry_count;
		sel = $urandom_range(0, 99);
		qx = 16'($urandom);
		qy = 16'($urandom);
		if (n > 0 && sel < 75) begin
			j = $urandom_range(0, n - 1);
			ecx = sb.region_table[j].cx;
			ecy = sb.region_table[j].cy;
			w = 2 * int'(sb.radius) + 1;
			if (sel < 45) begin
				qx = 16'(int'(ecx) + int'($urandom_range(0, 2 * w)) - w);
				qy = 16'(int'(ecy) + int'($urandom_range(0, 2 * w)) - w);
			end else if (sel < 60) begin
				qx = ecx;
				qy = ecy;
			end else begin
				qx = $urandom_range(0, 1) ? 16'(int'(ecx) + int'(sb.radius))
					: 16'(int'(ecx) - int'(sb.radius));
				qy = ecy;
			end
		end
		send_query(qx, qy);
	endtask

	task automatic run_phase(input logic [crml_pkg::RADIUS_W-1:0] r,
			input logic [crml_pkg::COUNT_W-1:0] c,
			input int words, input bit quiet, input bit hold, input bit pause);
		settle();
		write_reg(crml_pkg::REG_RADIUS, crml_pkg::CFG_W'(r));
		write_reg(crml_pkg::REG_COUNT, crml_pkg::CFG_W'(c));
		no_idle = quiet;
		if (hold)
			hold_req = 1'b1;
		for (int i = 0; i < words; i++) begin
			if (pause && i == words / 2) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (sb.pending() != 0)
					@(negedge clk);
			end
			if ($urandom_range(0, 99) < 30)
				send_load(6'($urandom_range(0, MAX_ENTRIES - 1)), random_coord(),
					random_coord(), random_mask());
			else
				random_query();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = crml_pkg::CMD_LOAD;
		entry_index = '0;
		center_x    = '0;
		center_y    = '0;
		entry_mask  = '0;
		point_x     = '0;
		point_y     = '0;
		cfg_wr_en   = 1'b0;
		cfg_index   = crml_pkg::REG_RADIUS;
		cfg_data    = '0;
		hold_req    = 1'b0;
		no_idle     = 1'b0;
		idle_cycles = 0;
		sb = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		send_query(16'sd0, 16'sd0);
		send_load(6'd0, 16'sd0, 16'sd0, 16'h1234);
		send_load(6'd1, 16'sh7fff, 16'sh7fff, 16'hffff);
		send_load(6'd2, 16'sh8000, 16'sh8000, 16'h0000);
		send_load(6'd3, 16'sh8000, 16'sh7fff, 16'h8000);
		send_load(6'd63, 16'sh5555, 16'shaaaa, 16'haaaa);

		settle();
		write_reg(crml_pkg::REG_RADIUS, crml_pkg::CFG_W'(1));
		write_reg(crml_pkg::REG_COUNT, crml_pkg::CFG_W'(4));
		send_query(16'sd0, 16'sd0);
		send_query(16'sd1, 16'sd0);
		send_query(16'sd1, 16'sd1);
		send_query(16'sh7fff, 16'sh7fff);
		send_query(16'sh8000, 16'sh8000);
		send_query(16'sh8000, 16'sh7fff);

		settle();
		write_reg(crml_pkg::REG_RADIUS, crml_pkg::CFG_W'(32767));
		send_query(16'sd0, 16'sd0);
		send_query(16'sh7fff, 16'sd0);
		send_query(16'sh8000, 16'sd0);

		settle();
		write_reg(crml_pkg::REG_RADIUS, crml_pkg::CFG_W'(0));
		send_query(16'sd0, 16'sd0);
		send_query(16'sd0, 16'sd1);

		for (int i = 0; i < MAX_ENTRIES; i++)
			send_load(6'(i), random_coord(), random_coord(), random_mask());

		run_phase(15'd448, 7'd64, PHASE_WORDS, 1'b0, 1'b1, 1'b0);
		run_phase(15'd1, 7'd1, PHASE_WORDS, 1'b0, 1'b0, 1'b1);
		run_phase(15'd32767, 7'd64, PHASE_WORDS, 1'b0, 1'b0, 1'b0);
		run_phase(15'd2000, 7'd127, PHASE_WORDS, 1'b1, 1'b0, 1'b0);
		run_phase(15'd32767, 7'd0, PHASE_WORDS, 1'b0, 1'b0, 1'b0);
		run_phase(15'd64, 7'd65, PHASE_WORDS, 1'b0, 1'b0, 1'b0);
		for (int p = 0; p < 4; p++)
			run_phase($urandom_range(0, 1) ? 15'($urandom_range(1, 32767))
				: 15'($urandom_range(1, 3000)),
				7'($urandom_range(1, MAX_ENTRIES)), PHASE_WORDS, 1'b0, 1'b0, 1'b0);

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("circle_region_mask_lookup_top test passed");
		else
			$display("circle_region_mask_lookup_top test failed");
		$finish;
	end

endmodule
